// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PSQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication
`define PSQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/psq_pkg.sv =====
// ----------------------------------------------------------------------------
// psq_pkg
// Types, constants and elaboration-time tables of the pitch quantizer.
// ----------------------------------------------------------------------------
package psq_pkg;

   localparam int FREQ_W         = 22;
   localparam int OVR_W          = 8;
   localparam int NOTE_W         = 9;
   localparam int DEV_W          = 11;
   localparam int P_W            = 16;
   localparam int LOG_W          = 21;
   localparam int ENT_W          = 17;
   localparam int REFERENCE_NOTE = 69;
   localparam int REFERENCE_HZ   = 440;
   localparam int LOG_TABLE_BITS = 8;
   localparam int LOG_DEPTH      = 1 << LOG_TABLE_BITS;
   localparam int EXP_DEPTH      = 1200;
   localparam int REF_CENTS      = 100 * REFERENCE_NOTE;
   localparam int DIV_OFS_OCT    = 21;
   localparam int KK_BIAS        = DIV_OFS_OCT + 8;

   localparam logic [11:0]       FULL_MASK = 12'hFFF;
   localparam logic [FREQ_W-1:0] FREQ_MAX  = '1;

   localparam logic [3:0] SCALE_CHROMATIC = 4'd0;
   localparam logic [3:0] SCALE_CUSTOM    = 4'd15;

   localparam logic [11:0] SCALE_PATTERNS [14] = '{
      12'hAB5, 12'h5AD, 12'h9AD, 12'hAAD, 12'h6AD, 12'h5AB, 12'hAD5,
      12'h6B5, 12'h56B, 12'h555, 12'h4E9, 12'h295, 12'h4A9, 12'hB6D
   };

   typedef enum logic [2:0] {
      CSR_SCALE_TYPE  = 3'd0,
      CSR_ROOT_NOTE   = 3'd1,
      CSR_CUSTOM_MASK = 3'd2,
      CSR_TRANSPOSE   = 3'd3,
      CSR_DETUNE      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [11:0]        mask;
      logic signed [5:0]  transpose;
      logic signed [7:0]  detune;
   } cfg_type;

   typedef struct packed {
      logic                     live;
      logic signed [NOTE_W-1:0] best;
      logic signed [P_W-1:0]    pitch;
   } note_type;

   typedef struct packed {
      logic                     live;
      logic signed [NOTE_W-1:0] note;
      logic signed [DEV_W-1:0]  dev;
      logic signed [P_W-1:0]    tp;
      logic [FREQ_W-1:0]        freq;
   } result_type;

   typedef logic [15:0]      log_rom_type [LOG_DEPTH];
   typedef logic [ENT_W-1:0] exp_rom_type [EXP_DEPTH];

   // log2 of a Q16 mantissa in [1,2), result Q16 truncated
   function automatic logic [15:0] log_frac(input logic [16:0] m);
      logic [63:0] x;
      logic [15:0] res;
      x   = 64'(m) << 14;
      res = '0;
      for (int i = 0; i < 16; i++) begin
         x   = (x * x) >> 30;
         res = {res[14:0], 1'b0};
         if (x >= 64'h8000_0000) begin
            res[0] = 1'b1;
            x      = x >> 1;
         end
      end
      return res;
   endfunction

   function automatic log_rom_type log_table();
      log_rom_type t;
      for (int i = 0; i < LOG_DEPTH; i++)
         t[i] = log_frac(17'(65536 + (i << (16 - LOG_TABLE_BITS))));
      return t;
   endfunction

   function automatic logic [LOG_W-1:0] log_q16(input logic [FREQ_W-1:0] v);
      logic [4:0]                       e;
      logic [FREQ_W+LOG_TABLE_BITS-1:0] sh;
      logic [LOG_TABLE_BITS-1:0]        idx;
      e = '0;
      for (int j = 0; j < FREQ_W; j++)
         if (v[j]) e = 5'(j);
      sh  = {v, {LOG_TABLE_BITS{1'b0}}} >> e;
      idx = sh[LOG_TABLE_BITS-1:0];
      return LOG_W'({e, 16'h0}) +
             LOG_W'(log_frac(17'(65536 + (int'(idx) << (16 - LOG_TABLE_BITS)))));
   endfunction

   function automatic exp_rom_type exp_table();
      exp_rom_type t;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      for (int r = 0; r < EXP_DEPTH; r++) begin
         lo = 64'd65536;
         hi = 64'd131071;
         for (int s = 0; s < 18; s++) begin
            if (lo < hi) begin
               mid = (lo + hi) >> 1;
               if (64'd1200 * 64'(log_frac(17'(mid))) >= 64'd65536 * 64'(r))
                  hi = mid;
               else
                  lo = mid + 64'd1;
            end
         end
         t[r] = ENT_W'(lo);
      end
      return t;
   endfunction

   localparam logic [LOG_W-1:0]   LOG_REF = log_q16(FREQ_W'(REFERENCE_HZ));
   localparam logic signed [22:0] LOG_OFS = 23'((8 << 16) + int'(LOG_REF));

endpackage

// ===== rtl/core/psq_csr.sv =====
// ----------------------------------------------------------------------------
// psq_csr
// Configuration registers and the active scale mask built from them.
// ----------------------------------------------------------------------------
module psq_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [11:0]       csr_data,
   output psq_pkg::cfg_type  cfg
);

   logic [3:0]        scale_type_ff, scale_type_in;
   logic [3:0]        root_ff, root_in;
   logic [11:0]       custom_ff, custom_in;
   logic signed [5:0] transpose_ff, transpose_in;
   logic signed [7:0] detune_ff, detune_in;
   logic [11:0]       mask_ff, mask_in;
   logic              hit;

   function automatic logic [11:0] build_mask(input logic [3:0] st, input logic [3:0] rt,
                                              input logic [11:0] cm);
      logic [3:0]  r;
      logic [11:0] p;
      logic [23:0] rot;
      logic [11:0] m;
      r   = (rt >= 4'd12) ? rt - 4'd12 : rt;
      p   = psq_pkg::SCALE_PATTERNS[st - 4'd1];
      rot = {p, p} << r;
      if (st == psq_pkg::SCALE_CHROMATIC)
         m = psq_pkg::FULL_MASK;
      else if (st == psq_pkg::SCALE_CUSTOM)
         m = cm;
      else
         m = rot[23:12];
      if (m == '0)
         m = psq_pkg::FULL_MASK;
      return m;
   endfunction

   assign csr_ready = 1'b1;

   always_comb begin
      scale_type_in = scale_type_ff;
      root_in       = root_ff;
      custom_in     = custom_ff;
      transpose_in  = transpose_ff;
      detune_in     = detune_ff;
      hit           = 1'b1;
      case (csr_index)
         psq_pkg::CSR_SCALE_TYPE:  scale_type_in = csr_data[3:0];
         psq_pkg::CSR_ROOT_NOTE:   root_in       = csr_data[3:0];
         psq_pkg::CSR_CUSTOM_MASK: custom_in     = csr_data;
         psq_pkg::CSR_TRANSPOSE:   transpose_in  = $signed(csr_data[5:0]);
         psq_pkg::CSR_DETUNE:      detune_in     = $signed(csr_data[7:0]);
         default:                  hit           = 1'b0;
      endcase
      mask_in = build_mask(scale_type_in, root_in, custom_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_type_ff <= psq_pkg::SCALE_CHROMATIC;
         root_ff       <= '0;
         custom_ff     <= psq_pkg::FULL_MASK;
         transpose_ff  <= '0;
         detune_ff     <= '0;
         mask_ff       <= psq_pkg::FULL_MASK;
      end else if (csr_valid && hit) begin
         scale_type_ff <= scale_type_in;
         root_ff       <= root_in;
         custom_ff     <= custom_in;
         transpose_ff  <= transpose_in;
         detune_ff     <= detune_in;
         mask_ff       <= mask_in;
      end
   end

   assign cfg = '{mask: mask_ff, transpose: transpose_ff, detune: detune_ff};

endmodule

// ===== rtl/core/psq_pitch.sv =====
// ----------------------------------------------------------------------------
// psq_pitch
// Frequency or override note to cents, transpose, semitone rounding and scale snapping.
// Six pipeline stages with per-stage flow control.
// ----------------------------------------------------------------------------
module psq_pitch (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_vld,
   output logic                                in_ready,
   input  logic [psq_pkg::FREQ_W-1:0]          freq,
   input  logic signed [psq_pkg::OVR_W-1:0]    ovr,
   input  psq_pkg::cfg_type                    cfg,
   output logic                                out_vld,
   input  logic                                out_ready,
   output psq_pkg::note_type                   note
);

   localparam int STAGES = 6;
   localparam int LTB    = psq_pkg::LOG_TABLE_BITS;
   localparam psq_pkg::log_rom_type LOG_ROM = psq_pkg::log_table();

   logic [STAGES-1:0] vld_ff, vld_in, en;

   // stage A: log2 of the frequency
   logic                          a_live_ff, a_live_in, a_ovr_ff, a_ovr_in;
   logic [6:0]                    a_note_ff;
   logic [psq_pkg::LOG_W-1:0]     a_log_ff, a_log_in;
   logic [4:0]                    lead;
   logic [psq_pkg::FREQ_W+LTB-1:0] lsh;
   logic [LTB-1:0]                lidx;

   // stage B: pitch in cents
   logic                           b_live_ff;
   logic signed [psq_pkg::P_W-1:0] b_p_ff, b_p_in;
   logic signed [22:0]             dlog;
   logic signed [33:0]             dw, dprod, dsh;
   logic signed [psq_pkg::P_W-1:0] ovp, pfr, tr16, trp;

   // stage C: round to semitone
   logic                              c_live_ff;
   logic signed [psq_pkg::P_W-1:0]    c_p_ff;
   logic signed [psq_pkg::NOTE_W-1:0] c_rnd_ff, c_rnd_in;
   logic [psq_pkg::P_W-1:0]           ap, nr;
   logic [31:0]                       qprod;
   logic [psq_pkg::NOTE_W-1:0]        qv;

   // stage D: residual and snap base
   logic                              d_live_ff, d_epos_ff, d_epos_in;
   logic signed [psq_pkg::P_W-1:0]    d_p_ff;
   logic signed [psq_pkg::NOTE_W-1:0] d_base_ff, d_base_in;
   logic signed [psq_pkg::P_W-1:0]    r16, e16;

   // stage E: pitch class of the base
   logic                              e_live_ff, e_epos_ff;
   logic signed [psq_pkg::P_W-1:0]    e_p_ff;
   logic signed [psq_pkg::NOTE_W-1:0] e_base_ff;
   logic [3:0]                        e_pc_ff, e_pc_in;
   logic signed [9:0]                 b10;
   logic [9:0]                        n12;
   logic [17:0]                       m12;
   logic [9:0]                        q12;

   // stage F: nearest enabled note
   logic                              f_live_ff;
   logic signed [psq_pkg::P_W-1:0]    f_p_ff;
   logic signed [psq_pkg::NOTE_W-1:0] f_best_ff, f_best_in;
   logic [23:0]                       rot24;
   logic [11:0]                       rot;
   logic [12:0]                       cen;
   logic signed [3:0]                 cdl [13];
   logic signed [3:0]                 delta;
   logic                              found;

   // flow control
   always_comb begin
      en[STAGES-1] = !vld_ff[STAGES-1] || out_ready;
      for (int i = STAGES - 2; i >= 0; i--)
         en[i] = !vld_ff[i] || en[i+1];
   end
   assign vld_in   = {vld_ff[STAGES-2:0], in_vld};
   assign in_ready = en[0];
   assign out_vld  = vld_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (en & vld_in) | (~en & vld_ff);
      end
   end

   // A
   always_comb begin
      lead = '0;
      for (int j = 0; j < psq_pkg::FREQ_W; j++)
         if (freq[j]) lead = 5'(j);
      lsh       = {freq, {LTB{1'b0}}} >> lead;
      lidx      = lsh[LTB-1:0];
      a_log_in  = psq_pkg::LOG_W'({lead, 16'h0}) + psq_pkg::LOG_W'(LOG_ROM[lidx]);
      a_ovr_in  = !ovr[psq_pkg::OVR_W-1];
      a_live_in = (freq != '0) || a_ovr_in;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_live_ff <= a_live_in;
         a_ovr_ff  <= a_ovr_in;
         a_note_ff <= ovr[6:0];
         a_log_ff  <= a_log_in;
      end
   end

   // B
   always_comb begin
      dlog   = $signed({2'b00, a_log_ff}) - psq_pkg::LOG_OFS;
      dw     = dlog;
      dprod  = dw * 34'sd1200;
      dsh    = (dprod + 34'sd32768) >>> 16;
      pfr    = $signed(dsh[15:0]) + $signed(16'(psq_pkg::REF_CENTS));
      ovp    = $signed(16'(a_note_ff)) * 16'sd100;
      tr16   = cfg.transpose;
      trp    = tr16 * 16'sd100;
      b_p_in = (a_ovr_ff ? ovp : pfr) + trp;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         b_live_ff <= a_live_ff;
         b_p_ff    <= b_p_in;
      end
   end

   // C: half away from zero, divide by 100 through a reciprocal
   always_comb begin
      ap       = b_p_ff[psq_pkg::P_W-1] ? 16'(-b_p_ff) : 16'(b_p_ff);
      nr       = ap + 16'd50;
      qprod    = 32'(nr) * 32'd5243;
      qv       = 9'(qprod >> 19);
      c_rnd_in = b_p_ff[psq_pkg::P_W-1] ? -$signed(qv) : $signed(qv);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         c_live_ff <= b_live_ff;
         c_p_ff    <= b_p_ff;
         c_rnd_ff  <= c_rnd_in;
      end
   end

   // D: a residual of -50 is moved to +50 on the lower note
   always_comb begin
      r16 = c_rnd_ff;
      e16 = c_p_ff - r16 * 16'sd100;
      if (e16 == -16'sd50) begin
         d_base_in = c_rnd_ff - 9'sd1;
         d_epos_in = 1'b1;
      end else begin
         d_base_in = c_rnd_ff;
         d_epos_in = (e16 > 16'sd0);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         d_live_ff <= c_live_ff;
         d_p_ff    <= c_p_ff;
         d_base_ff <= d_base_in;
         d_epos_ff <= d_epos_in;
      end
   end

   // E: modulo 12 of a biased nonnegative value
   always_comb begin
      b10     = d_base_ff;
      n12     = 10'(b10 + 10'sd216);
      m12     = 18'(n12) * 18'd171;
      q12     = 10'(m12 >> 11);
      e_pc_in = 4'(n12 - 10'(q12 * 10'd12));
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         e_live_ff <= d_live_ff;
         e_p_ff    <= d_p_ff;
         e_base_ff <= d_base_ff;
         e_epos_ff <= d_epos_ff;
         e_pc_ff   <= e_pc_in;
      end
   end

   // F: candidates in order of distance, lower note first on a tie
   always_comb begin
      rot24  = {cfg.mask, cfg.mask} >> e_pc_ff;
      rot    = rot24[11:0];
      cen[0] = rot[0];
      cdl[0] = 4'sd0;
      for (int k = 1; k <= 6; k++) begin
         cen[2*k-1] = e_epos_ff ? rot[k] : rot[12-k];
         cdl[2*k-1] = e_epos_ff ? 4'(k) : -4'(k);
         cen[2*k]   = e_epos_ff ? rot[12-k] : rot[k];
         cdl[2*k]   = e_epos_ff ? -4'(k) : 4'(k);
      end
      found = 1'b0;
      delta = '0;
      for (int j = 0; j < 13; j++) begin
         if (!found && cen[j]) begin
            found = 1'b1;
            delta = cdl[j];
         end
      end
      f_best_in = e_base_ff + 9'(delta);
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         f_live_ff <= e_live_ff;
         f_p_ff    <= e_p_ff;
         f_best_ff <= f_best_in;
      end
   end

   assign note = '{live: f_live_ff, best: f_best_ff, pitch: f_p_ff};

endmodule

// ===== rtl/core/psq_synth.sv =====
// ----------------------------------------------------------------------------
// psq_synth
// Deviation, detuned target pitch and target frequency via the exp2 ROM.
// Five pipeline stages; the frequency shift feeds the output register.
// ----------------------------------------------------------------------------
module psq_synth (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   output logic                in_ready,
   input  psq_pkg::note_type   note,
   input  psq_pkg::cfg_type    cfg,
   output logic                out_vld,
   input  logic                out_ready,
   output psq_pkg::result_type res
);

   localparam int STAGES = 5;
   localparam psq_pkg::exp_rom_type EXP_ROM = psq_pkg::exp_table();

   logic [STAGES-1:0] vld_ff, vld_in, en;

   logic                              g_live_ff, h_live_ff, i_live_ff, j_live_ff, k_live_ff;
   logic signed [psq_pkg::NOTE_W-1:0] g_best_ff, h_best_ff, i_best_ff, j_best_ff, k_best_ff;
   logic signed [psq_pkg::DEV_W-1:0]  g_dev_ff, h_dev_ff, i_dev_ff, j_dev_ff, k_dev_ff;
   logic signed [psq_pkg::P_W-1:0]    g_tp_ff, h_tp_ff, i_tp_ff, j_tp_ff, k_tp_ff;

   logic signed [psq_pkg::P_W-1:0] best16, dev16, det16, g_tp_in;
   logic signed [psq_pkg::DEV_W-1:0] g_dev_in;

   logic signed [16:0] xw;
   logic [15:0]        h_n_ff, h_n_in;
   logic [31:0]        hq;
   logic [4:0]         h_q_ff, h_q_in;

   logic [16:0]        r0;
   logic [10:0]        i_addr_ff, i_addr_in;
   logic [4:0]         qf;
   logic signed [6:0]  i_kk_ff, i_kk_in, j_kk_ff, k_kk_ff;

   logic [psq_pkg::ENT_W-1:0] j_ent_ff;
   logic [25:0]               k_v_ff, k_v_in;

   logic [4:0]                s;
   logic [30:0]               rsum, rsh;
   logic [psq_pkg::FREQ_W-1:0] fout;

   always_comb begin
      en[STAGES-1] = !vld_ff[STAGES-1] || out_ready;
      for (int i = STAGES - 2; i >= 0; i--)
         en[i] = !vld_ff[i] || en[i+1];
   end
   assign vld_in   = {vld_ff[STAGES-2:0], in_vld};
   assign in_ready = en[0];
   assign out_vld  = vld_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (en & vld_in) | (~en & vld_ff);
      end
   end

   // G
   always_comb begin
      best16   = note.best;
      det16    = cfg.detune;
      dev16    = note.pitch - best16 * 16'sd100;
      g_dev_in = dev16[psq_pkg::DEV_W-1:0];
      g_tp_in  = best16 * 16'sd100 + det16;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         g_live_ff <= note.live;
         g_best_ff <= note.best;
         g_dev_ff  <= g_dev_in;
         g_tp_ff   <= g_tp_in;
      end
   end

   // H: biased offset from the reference, octave estimate
   always_comb begin
      xw     = 17'(g_tp_ff) - $signed(17'(psq_pkg::REF_CENTS))
               + $signed(17'(1200 * psq_pkg::DIV_OFS_OCT));
      h_n_in = xw[15:0];
      hq     = 32'(h_n_in) * 32'd873;
      h_q_in = 5'(hq >> 20);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         h_live_ff <= g_live_ff;
         h_best_ff <= g_best_ff;
         h_dev_ff  <= g_dev_ff;
         h_tp_ff   <= g_tp_ff;
         h_n_ff    <= h_n_in;
         h_q_ff    <= h_q_in;
      end
   end

   // I: one correction step
   always_comb begin
      r0 = 17'(h_n_ff) - 17'(h_q_ff) * 17'd1200;
      if (r0 >= 17'd1200) begin
         i_addr_in = 11'(r0 - 17'd1200);
         qf        = h_q_ff + 5'd1;
      end else begin
         i_addr_in = 11'(r0);
         qf        = h_q_ff;
      end
      i_kk_in = $signed({2'b00, qf}) - $signed(7'(psq_pkg::KK_BIAS));
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         i_live_ff <= h_live_ff;
         i_best_ff <= h_best_ff;
         i_dev_ff  <= h_dev_ff;
         i_tp_ff   <= h_tp_ff;
         i_addr_ff <= i_addr_in;
         i_kk_ff   <= i_kk_in;
      end
   end

   // J: ROM read
   always_ff @(posedge clock) begin
      if (en[3]) begin
         j_live_ff <= i_live_ff;
         j_best_ff <= i_best_ff;
         j_dev_ff  <= i_dev_ff;
         j_tp_ff   <= i_tp_ff;
         j_kk_ff   <= i_kk_ff;
         j_ent_ff  <= EXP_ROM[i_addr_ff];
      end
   end

   // K
   assign k_v_in = 26'(j_ent_ff) * 26'(psq_pkg::REFERENCE_HZ);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         k_live_ff <= j_live_ff;
         k_best_ff <= j_best_ff;
         k_dev_ff  <= j_dev_ff;
         k_tp_ff   <= j_tp_ff;
         k_kk_ff   <= j_kk_ff;
         k_v_ff    <= k_v_in;
      end
   end

   // octave shift, round half up, saturate
   always_comb begin
      s    = 5'(-k_kk_ff);
      rsum = 31'(k_v_ff) + (31'd1 << (s - 5'd1));
      rsh  = rsum >> s;
      if (!k_kk_ff[6])
         fout = psq_pkg::FREQ_MAX;
      else if (rsh > 31'(psq_pkg::FREQ_MAX))
         fout = psq_pkg::FREQ_MAX;
      else
         fout = rsh[psq_pkg::FREQ_W-1:0];
   end

   assign res = '{live: k_live_ff, note: k_best_ff, dev: k_dev_ff, tp: k_tp_ff, freq: fout};

endmodule

// ===== rtl/core/pitch_to_scale_quantizer.sv =====
// ----------------------------------------------------------------------------
// pitch_to_scale_quantizer
// Snaps a detected frequency or an override note to the active musical scale.
//
// req_ channel: one beat carries a Q14.8 frequency and a signed override
//   note; a nonnegative override wins, neither present gives an invalid result.
// rsp_ channel: one beat per request: valid flag, snapped note, deviation,
//   detuned target pitch in cents and target frequency in Q14.8.
// csr_ channel: register index and data, always ready; it must be written while idle, which the block does not enforce.
// Throughput: one request per cycle; 12 pipeline stages and the output
//   register each hold one item, the ROM read takes one of those stages.
// Reset: all stages empty, registers at defaults, chromatic mask.
// Stall: a held response stalls each stage only once it and all later
//   stages are full; empty stages keep filling and req_ready stays high
//   until the whole pipeline is occupied.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pitch_to_scale_quantizer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [psq_pkg::FREQ_W-1:0]             req_frequency_hz,
   input  logic signed [psq_pkg::OVR_W-1:0]       req_midi_override,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid_res,
   output logic signed [psq_pkg::NOTE_W-1:0]      rsp_target_note,
   output logic signed [psq_pkg::DEV_W-1:0]       rsp_deviation_cents,
   output logic signed [psq_pkg::P_W-1:0]         rsp_target_pitch_cents,
   output logic [psq_pkg::FREQ_W-1:0]             rsp_target_frequency_hz,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [2:0]                             csr_index,
   input  logic [11:0]                            csr_data
);

   psq_pkg::cfg_type    cfg;
   psq_pkg::note_type   note;
   psq_pkg::result_type res;

   logic                               in_vld_ff, in_en;
   logic [psq_pkg::FREQ_W-1:0]         in_freq_ff;
   logic signed [psq_pkg::OVR_W-1:0]   in_ovr_ff;
   logic                               pitch_ready, note_vld, synth_ready, res_vld;

   logic                               rsp_valid_ff, out_en;
   logic                               valid_res_ff;
   logic signed [psq_pkg::NOTE_W-1:0]  note_ff;
   logic signed [psq_pkg::DEV_W-1:0]   dev_ff;
   logic signed [psq_pkg::P_W-1:0]     tp_ff;
   logic [psq_pkg::FREQ_W-1:0]         freq_ff;
   logic signed [psq_pkg::P_W-1:0]     chk_pitch;

   psq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // input register
   assign in_en     = !in_vld_ff || pitch_ready;
   assign req_ready = in_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (in_en) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_en && req_valid) begin
         in_freq_ff <= req_frequency_hz;
         in_ovr_ff  <= req_midi_override;
      end
   end

   psq_pitch u_pitch (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (in_vld_ff),
      .in_ready  (pitch_ready),
      .freq      (in_freq_ff),
      .ovr       (in_ovr_ff),
      .cfg       (cfg),
      .out_vld   (note_vld),
      .out_ready (synth_ready),
      .note      (note)
   );

   psq_synth u_synth (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (note_vld),
      .in_ready  (synth_ready),
      .note      (note),
      .cfg       (cfg),
      .out_vld   (res_vld),
      .out_ready (out_en),
      .res       (res)
   );

   // output register
   assign out_en = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= res_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && res_vld) begin
         valid_res_ff <= res.live;
         note_ff      <= res.live ? res.note : '0;
         dev_ff       <= res.live ? res.dev  : '0;
         tp_ff        <= res.live ? res.tp   : '0;
         freq_ff      <= res.live ? res.freq : '0;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_valid_res           = valid_res_ff;
   assign rsp_target_note         = note_ff;
   assign rsp_deviation_cents     = dev_ff;
   assign rsp_target_pitch_cents  = tp_ff;
   assign rsp_target_frequency_hz = freq_ff;

   assign chk_pitch = psq_pkg::P_W'(rsp_target_note) * 16'sd100 +
                      psq_pkg::P_W'(cfg.detune);

   `PSQ_ASSERT(a_mask_nonzero, cfg.mask != '0, "scale mask is empty")
   `PSQ_ASSERT_IMPL(a_pitch_sum, rsp_valid && rsp_valid_res,
      rsp_target_pitch_cents == chk_pitch, "target pitch does not match note and detune")
   `PSQ_ASSERT_IMPL(a_dev_range, rsp_valid && rsp_valid_res,
      rsp_deviation_cents <= 11'sd650 && rsp_deviation_cents >= -11'sd650,
      "deviation out of range")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the pitch-to-scale quantizer. Drives frequency and override
// beats through several register settings, predicts each response from a
// bit-true integer model of the pitch math and compares every field in order.
// ----------------------------------------------------------------------------
module tb;
   import psq_pkg::*;

   class pitch_scoreboard;
      result_type  expected_q[$];
      int          errors;
      logic [3:0]  scale_sel;
      logic [3:0]  root;
      logic [11:0] custom;
      logic [5:0]  transpose;
      logic [7:0]  detune;
      logic [11:0] mask;
      longint unsigned exp_mant [EXP_DEPTH];

      static function longint unsigned mant_log(longint unsigned m);
         longint unsigned x;
         longint unsigned res;
         x   = m << 14;
         res = 0;
         for (int i = 0; i < 16; i++) begin
            x   = (x * x) >> 30;
            res = res << 1;
            if (x >= 64'h8000_0000) begin
               res = res | 1;
               x   = x >> 1;
            end
         end
         return res;
      endfunction

      static function longint pitch_log(longint unsigned v);
         int              e;
         longint unsigned idx;
         e = 0;
         while (e < 63 && (v >> (e + 1)) != 0)
            e++;
         if (e >= LOG_TABLE_BITS)
            idx = (v >> (e - LOG_TABLE_BITS)) & 255;
         else
            idx = (v << (LOG_TABLE_BITS - e)) & 255;
         return (longint'(e) << 16) + longint'(mant_log(65536 + (idx << 8)));
      endfunction

      function new();
         longint unsigned lo, hi, mid;
         errors = 0;
         reset_regs();
         for (int r = 0; r < EXP_DEPTH; r++) begin
            lo = 65536;
            hi = 131071;
            while (lo < hi) begin
               mid = (lo + hi) >> 1;
               if (1200 * mant_log(mid) >= 65536 * longint'(r))
                  hi = mid;
               else
                  lo = mid + 1;
            end
            exp_mant[r] = lo;
         end
      endfunction

      function void reset_regs();
         scale_sel = SCALE_CHROMATIC;
         root      = 0;
         custom    = FULL_MASK;
         transpose = 0;
         detune    = 0;
         mask      = FULL_MASK;
      endfunction

      function void write_reg(logic [2:0] idx, logic [11:0] data);
         logic [11:0] p;
         int          r;
         case (idx)
            CSR_SCALE_TYPE:  scale_sel = data[3:0];
            CSR_ROOT_NOTE:   root      = data[3:0];
            CSR_CUSTOM_MASK: custom    = data;
            CSR_TRANSPOSE:   transpose = data[5:0];
            CSR_DETUNE:      detune    = data[7:0];
            default:         return;
         endcase
         r = root % 12;
         if (scale_sel == SCALE_CHROMATIC)
            mask = FULL_MASK;
         else if (scale_sel == SCALE_CUSTOM)
            mask = custom;
         else begin
            p    = SCALE_PATTERNS[scale_sel - 1];
            mask = 12'((24'(p) << r) | (24'(p) >> (12 - r)));
         end
         if (mask == 0)
            mask = FULL_MASK;
      endfunction

      function void note_request(logic [FREQ_W-1:0] freq, logic signed [7:0] ovr);
         result_type      res;
         longint          p, rounded, best, best_gap, c, pc, gap, tp, x, k, r;
         longint unsigned v, fout;
         int              s;
         res = '0;
         if (freq == 0 && ovr < 0) begin
            expected_q.push_back(res);
            return;
         end
         if (ovr >= 0)
            p = 100 * longint'(ovr);
         else
            p = REF_CENTS + ((1200 * (pitch_log(freq) - (8 << 16) - pitch_log(REFERENCE_HZ))
                              + 32768) >>> 16);
         p += 100 * longint'($signed(transpose));
         if (p >= 0)
            rounded = (p + 50) / 100;
         else
            rounded = -((-p + 50) / 100);
         best     = 0;
         best_gap = 64'h7FFF_FFFF_FFFF_FFFF;
         for (int dl = -12; dl <= 12; dl++) begin
            c  = rounded + dl;
            pc = ((c % 12) + 12) % 12;
            if (mask[pc]) begin
               gap = 100 * c - p;
               if (gap < 0)
                  gap = -gap;
               if (gap < best_gap) begin
                  best_gap = gap;
                  best     = c;
               end
            end
         end
         tp = 100 * best + longint'($signed(detune));
         x  = tp - REF_CENTS;
         k  = (x >= 0) ? x / 1200 : -((-x + 1199) / 1200);
         r  = x - 1200 * k;
         v  = REFERENCE_HZ * exp_mant[r];
         k -= 8;
         if (k >= 0) begin
            if (k > 30)
               fout = FREQ_MAX;
            else begin
               fout = v << k;
               if (fout > FREQ_MAX)
                  fout = FREQ_MAX;
            end
         end else if (k < -40)
            fout = 0;
         else begin
            s    = int'(-k);
            fout = (v + (64'd1 << (s - 1))) >> s;
            if (fout > FREQ_MAX)
               fout = FREQ_MAX;
         end
         res.live = 1'b1;
         res.note = NOTE_W'(best);
         res.dev  = DEV_W'(p - 100 * best);
         res.tp   = P_W'(tp);
         res.freq = FREQ_W'(fout);
         expected_q.push_back(res);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check_response(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            report("unexpected beat", 1, 0);
            return;
         end
         want = expected_q.pop_front();
         if (got.live !== want.live) report("valid_res", got.live, want.live);
         if (got.note !== want.note) report("target_note", got.note, want.note);
         if (got.dev !== want.dev) report("deviation_cents", got.dev, want.dev);
         if (got.tp !== want.tp) report("target_pitch_cents", got.tp, want.tp);
         if (got.freq !== want.freq) report("target_frequency_hz", got.freq, want.freq);
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FREQ_W-1:0]        req_frequency_hz = '0;
   logic signed [OVR_W-1:0]  req_midi_override = -8'sd1;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_valid_res;
   logic signed [NOTE_W-1:0] rsp_target_note;
   logic signed [DEV_W-1:0]  rsp_deviation_cents;
   logic signed [P_W-1:0]    rsp_target_pitch_cents;
   logic [FREQ_W-1:0]        rsp_target_frequency_hz;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [2:0]               csr_index = '0;
   logic [11:0]              csr_data = '0;

   pitch_scoreboard sb = new();
   bit              busy_stretch = 1'b0;
   int              cycles = 0;

   pitch_to_scale_quantizer dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("[pitch_to_scale_quantizer] ERROR");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ready <= busy_stretch || ($urandom_range(0, 99) >= 13);

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response('{rsp_valid_res, rsp_target_note, rsp_deviation_cents,
                             rsp_target_pitch_cents, rsp_target_frequency_hz});

   task write_csr(logic [2:0] idx, logic [11:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task send_beat(logic [FREQ_W-1:0] freq, logic signed [7:0] ovr);
      if (!busy_stretch && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_frequency_hz  <= freq;
      req_midi_override <= ovr;
      do @(posedge clock); while (!req_ready);
      sb.note_request(freq, ovr);
      @(negedge clock);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
   endtask

   task random_beat();
      int          e;
      int unsigned pick;
      logic [21:0] f;
      pick = $urandom_range(0, 99);
      e    = $urandom_range(0, 21);
      f    = 22'((32'd1 << e) | ($urandom & ((32'd1 << e) - 1)));
      if (pick < 35)
         send_beat(22'($urandom), 8'($urandom_range(0, 127)));
      else if (pick < 45)
         send_beat(22'($urandom), 8'($urandom_range(128, 255)));
      else if (pick < 48)
         send_beat('0, 8'($urandom_range(128, 255)));
      else if (pick < 60)
         send_beat(22'($urandom), -8'sd1);
      else
         send_beat(f, -8'sd1);
   endtask

   task config_all(logic [11:0] st, logic [11:0] rn, logic [11:0] cm,
                   logic [11:0] tr, logic [11:0] dt);
      write_csr(CSR_SCALE_TYPE, st);
      write_csr(CSR_ROOT_NOTE, rn);
      write_csr(CSR_CUSTOM_MASK, cm);
      write_csr(CSR_TRANSPOSE, tr);
      write_csr(CSR_DETUNE, dt);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_beat('0, -8'sd1);
      send_beat('0, -8'sd128);
      send_beat('0, 8'sd0);
      send_beat('0, 8'sd127);
      send_beat(22'h3FFFFF, -8'sd1);
      send_beat(22'h3FFFFF, 8'sd127);
      send_beat(22'd1, -8'sd1);
      send_beat(22'd1, -8'sd100);
      send_beat(22'd255, -8'sd1);
      send_beat(22'd256, -8'sd1);
      send_beat(22'(440 * 256), -8'sd1);
      send_beat(22'(440 * 256 + 3789), -8'sd1);
      send_beat(22'd5000, 8'sd60);
      drain();

      config_all(12'd15, 12'd0, 12'h000, 12'h01F, 12'h07F);
      for (int i = 0; i < 12; i++) random_beat();
      send_beat(22'h3FFFFF, 8'sd127);
      drain();
      config_all(12'd14, 12'd11, 12'hFFF, 12'h020, 12'h080);
      for (int i = 0; i < 12; i++) random_beat();
      send_beat(22'd1, 8'sd0);
      send_beat(22'd1, -8'sd1);
      drain();
      config_all(12'hFFF, 12'hFFF, 12'h801, 12'hFE8, 12'hF9C);
      write_csr(3'd5, 12'hFFF);
      write_csr(3'd7, 12'h000);
      for (int i = 0; i < 10; i++) random_beat();
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         config_all(12'($urandom_range(0, 15)), 12'($urandom_range(0, 15)),
                    12'($urandom), 12'($urandom), 12'($urandom));
         write_csr(3'($urandom_range(5, 7)), 12'($urandom));
         busy_stretch = (ph == 4);
         for (int i = 0; i < 90; i++) random_beat();
         busy_stretch = 1'b0;
         drain();
      end

      if (sb.errors == 0)
         $display("[pitch_to_scale_quantizer] OK");
      else
         $display("[pitch_to_scale_quantizer] ERROR");
      $finish;
   end
endmodule
